// ----- hw/rtl/vpcs_pkg.sv -----
package vpcs_pkg;

  // sample and field widths
  localparam int unsigned X_W        = 16;
  localparam int unsigned HP_W       = 24;
  localparam int unsigned D_W        = 25;
  localparam int unsigned PV_W       = 24;
  localparam int unsigned MAG_W      = 24;
  localparam int unsigned COEF_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DRIVE_W    = 14;
  localparam int unsigned Q_SHIFT    = 15;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // tanh table geometry
  localparam int unsigned TANH_LOG2    = 8;
  localparam int unsigned TANH_ENTRIES = 1 << TANH_LOG2;
  localparam int unsigned ADDR_W       = TANH_LOG2 + 1;
  localparam int unsigned POS_SHIFT    = 30;
  localparam int unsigned FRAC_W       = POS_SHIFT - TANH_LOG2;
  localparam int unsigned DRV_PROD_W   = MAG_W + DRIVE_W;
  localparam int unsigned IDX_W        = DRV_PROD_W - FRAC_W;

  // shared multiplier operand widths
  localparam int unsigned MA_W = 26;
  localparam int unsigned MB_W = (FRAC_W + 1 > GAIN_W + 1) ? FRAC_W + 1 : GAIN_W + 1;
  localparam int unsigned P_W  = MA_W + MB_W;

  // register reset values and clamp limits
  localparam logic [COEF_W-1:0]  HP_COEF_RST  = 15'd32304;
  localparam logic [COEF_W-1:0]  PRES_RST     = 15'd9830;
  localparam logic [COEF_W-1:0]  PRES_MAX     = 15'd26214;
  localparam logic [COEF_W-1:0]  THRESH_RST   = 15'd19661;
  localparam logic [COEF_W-1:0]  THRESH_MIN   = 15'd6554;
  localparam logic [COEF_W-1:0]  THRESH_MAX   = 15'd29491;
  localparam logic [GAIN_W-1:0]  SLOPE_RST    = 16'd8192;
  localparam logic [GAIN_W-1:0]  SLOPE_MIN    = 16'd2731;
  localparam logic [GAIN_W-1:0]  SLOPE_MAX    = 16'd32768;
  localparam logic [DRIVE_W-1:0] DRIVE_RST    = 14'd4096;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN    = 14'd2048;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX    = 14'd12288;
  localparam logic [GAIN_W-1:0]  OGAIN_RST    = 16'd29491;
  localparam logic [GAIN_W-1:0]  OGAIN_MIN    = 16'd3277;
  localparam logic [GAIN_W-1:0]  OGAIN_MAX    = 16'd32768;
  localparam logic [COEF_W-1:0]  CEIL_RST     = 15'd31130;
  localparam logic [COEF_W-1:0]  CEIL_MIN     = 15'd22938;
  localparam logic [COEF_W-1:0]  CEIL_MAX     = 15'd32440;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_HP_COEF  = 3'd1,
    REG_PRESENCE = 3'd2,
    REG_THRESH   = 3'd3,
    REG_SLOPE    = 3'd4,
    REG_DRIVE    = 3'd5,
    REG_OGAIN    = 3'd6,
    REG_CEILING  = 3'd7
  } reg_idx_e;

  // register file contents seen by the datapath
  typedef struct packed {
    logic                enable;
    logic [COEF_W-1:0]   hp_coef;
    logic [COEF_W-1:0]   presence;
    logic [COEF_W-1:0]   thresh;
    logic [GAIN_W-1:0]   slope;
    logic [DRIVE_W-1:0]  drive;
    logic [GAIN_W-1:0]   out_gain;
    logic [COEF_W-1:0]   ceiling;
  } cfg_t;

  // datapath operations, one per sequencer step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_HP,
    OP_HP,
    OP_MUL_PRES,
    OP_MIX,
    OP_KNEE,
    OP_MUL_SLOPE,
    OP_COMP,
    OP_MUL_DRIVE,
    OP_INDEX,
    OP_LUT_A,
    OP_LUT_B,
    OP_MUL_FRAC,
    OP_INTERP,
    OP_MUL_OUT,
    OP_FINAL,
    OP_BYPASS
  } dp_op_e;

  typedef struct packed {
    logic   load;
    logic   out_load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // tanh(8k/N) in Q1.15 from an exp series, squared up and divided out
  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // unsigned shift and subtract division, only evaluated while building the table
  function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], dividend[i]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] tanh_point(int unsigned k);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    int unsigned n;
    int unsigned j;
    term = Q31_ONE;
    sum  = Q31_ONE;
    for (n = 1; n <= 24; n++) begin
      term = udiv64(term * 64'(k), 64'(TANH_ENTRIES) * 64'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = sum;
    for (j = 0; j < 4; j++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    num = (Q31_ONE - e) << 15;
    den = Q31_ONE + e;
    return 16'(udiv64(num + (den >> 1), den));
  endfunction

  typedef logic [15:0] tanh_rom_t [TANH_ENTRIES+1];

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    int unsigned k;
    for (k = 0; k <= TANH_ENTRIES; k++) begin
      rom[k] = tanh_point(k);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ----- hw/rtl/vpcs_cfg.sv -----
module vpcs_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vpcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vpcs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output vpcs_pkg::cfg_t                      cfg_o,
  output logic                                hist_clr_o
);
  import vpcs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  logic [COEF_W-1:0]  v15;
  logic [GAIN_W-1:0]  v16;
  logic [DRIVE_W-1:0] v14;

  assign cfg_ready_o = 1'b1;
  assign wr  = cfg_valid_i & cfg_ready_o;
  assign v15 = cfg_data_i[COEF_W-1:0];
  assign v16 = cfg_data_i[GAIN_W-1:0];
  assign v14 = cfg_data_i[DRIVE_W-1:0];

  // a change of the enable value wipes the filter history
  assign hist_clr_o = wr && (reg_idx_e'(cfg_index_i) == REG_ENABLE)
                      && (cfg_data_i[0] != cfg_q.enable);

  // register writes; all but the enable and high-pass coefficient values are saturated into their working range
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ENABLE:   cfg_d.enable  = cfg_data_i[0];
        REG_HP_COEF:  cfg_d.hp_coef = v15;
        REG_PRESENCE: cfg_d.presence = (v15 > PRES_MAX) ? PRES_MAX : v15;
        REG_THRESH: begin
          if (v15 < THRESH_MIN) cfg_d.thresh = THRESH_MIN;
          else if (v15 > THRESH_MAX) cfg_d.thresh = THRESH_MAX;
          else cfg_d.thresh = v15;
        end
        REG_SLOPE: begin
          if (v16 < SLOPE_MIN) cfg_d.slope = SLOPE_MIN;
          else if (v16 > SLOPE_MAX) cfg_d.slope = SLOPE_MAX;
          else cfg_d.slope = v16;
        end
        REG_DRIVE: begin
          if (v14 < DRIVE_MIN) cfg_d.drive = DRIVE_MIN;
          else if (v14 > DRIVE_MAX) cfg_d.drive = DRIVE_MAX;
          else cfg_d.drive = v14;
        end
        REG_OGAIN: begin
          if (v16 < OGAIN_MIN) cfg_d.out_gain = OGAIN_MIN;
          else if (v16 > OGAIN_MAX) cfg_d.out_gain = OGAIN_MAX;
          else cfg_d.out_gain = v16;
        end
        REG_CEILING: begin
          if (v15 < CEIL_MIN) cfg_d.ceiling = CEIL_MIN;
          else if (v15 > CEIL_MAX) cfg_d.ceiling = CEIL_MAX;
          else cfg_d.ceiling = v15;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.hp_coef  <= HP_COEF_RST;
      cfg_q.presence <= PRES_RST;
      cfg_q.thresh   <= THRESH_RST;
      cfg_q.slope    <= SLOPE_RST;
      cfg_q.drive    <= DRIVE_RST;
      cfg_q.out_gain <= OGAIN_RST;
      cfg_q.ceiling  <= CEIL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/vpcs_ctrl.sv -----
module vpcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              enable_i,
  input  vpcs_pkg::dp_sts_t sts_i,
  output vpcs_pkg::dp_cmd_t cmd_o
);
  import vpcs_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_MUL_HP    = 16'h0002,
    S_HP        = 16'h0004,
    S_MUL_PRES  = 16'h0008,
    S_MIX       = 16'h0010,
    S_KNEE      = 16'h0020,
    S_MUL_SLOPE = 16'h0040,
    S_COMP      = 16'h0080,
    S_MUL_DRIVE = 16'h0100,
    S_INDEX     = 16'h0200,
    S_LUT_A     = 16'h0400,
    S_LUT_B     = 16'h0800,
    S_MUL_FRAC  = 16'h1000,
    S_INTERP    = 16'h2000,
    S_MUL_OUT   = 16'h4000,
    S_FINAL     = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   bypass_q, bypass_d;
  logic   accept;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i & s_ready_o;

  // step sequencing; the last step holds until the output register is free
  always_comb begin
    state_d      = state_q;
    bypass_d     = bypass_q;
    cmd_o.load     = accept;
    cmd_o.out_load = 1'b0;
    cmd_o.op       = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          bypass_d = ~enable_i;
          state_d  = enable_i ? S_MUL_HP : S_FINAL;
        end
      end
      S_MUL_HP:    begin cmd_o.op = OP_MUL_HP;    state_d = S_HP;        end
      S_HP:        begin cmd_o.op = OP_HP;        state_d = S_MUL_PRES;  end
      S_MUL_PRES:  begin cmd_o.op = OP_MUL_PRES;  state_d = S_MIX;       end
      S_MIX:       begin cmd_o.op = OP_MIX;       state_d = S_KNEE;      end
      S_KNEE:      begin cmd_o.op = OP_KNEE;      state_d = S_MUL_SLOPE; end
      S_MUL_SLOPE: begin cmd_o.op = OP_MUL_SLOPE; state_d = S_COMP;      end
      S_COMP:      begin cmd_o.op = OP_COMP;      state_d = S_MUL_DRIVE; end
      S_MUL_DRIVE: begin cmd_o.op = OP_MUL_DRIVE; state_d = S_INDEX;     end
      S_INDEX:     begin cmd_o.op = OP_INDEX;     state_d = S_LUT_A;     end
      S_LUT_A:     begin cmd_o.op = OP_LUT_A;     state_d = S_LUT_B;     end
      S_LUT_B:     begin cmd_o.op = OP_LUT_B;     state_d = S_MUL_FRAC;  end
      S_MUL_FRAC:  begin cmd_o.op = OP_MUL_FRAC;  state_d = S_INTERP;    end
      S_INTERP:    begin cmd_o.op = OP_INTERP;    state_d = S_MUL_OUT;   end
      S_MUL_OUT:   begin cmd_o.op = OP_MUL_OUT;   state_d = S_FINAL;     end
      S_FINAL: begin
        cmd_o.op = bypass_q ? OP_BYPASS : OP_FINAL;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bypass_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bypass_q <= bypass_d;
    end
  end

  // a disabled item goes straight to the output step
  a_bypass_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !enable_i) |=> (state_q == S_FINAL && bypass_q))
    else $error("disabled item did not take the bypass route");

  // the output register is only loaded when it can take a result
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output loaded while still occupied");

endmodule

// ----- hw/rtl/vpcs_dp.sv -----
module vpcs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vpcs_pkg::cfg_t             cfg_i,
  input  logic                       hist_clr_i,
  input  vpcs_pkg::dp_cmd_t          cmd_i,
  output vpcs_pkg::dp_sts_t          sts_o,
  input  logic [vpcs_pkg::X_W-1:0]   x_i,
  input  logic                       ch_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [vpcs_pkg::X_W-1:0]   out_data_o
);
  import vpcs_pkg::*;

  localparam logic signed [P_W-1:0] RND_HALF = P_W'(1) <<< (Q_SHIFT - 1);
  localparam logic signed [P_W-1:0] HP_MAX_P = P_W'((1 << (HP_W - 1)) - 1);
  localparam logic signed [P_W-1:0] HP_MIN_P = -HP_MAX_P - P_W'(1);

  // filter history, one slot per channel group
  logic signed [X_W-1:0]  last_in_q [2];
  logic signed [HP_W-1:0] last_hp_q [2];

  // per-item working registers
  logic signed [X_W-1:0]   x_q;
  logic                    ch_q;
  logic signed [D_W-1:0]   d_q;
  logic signed [HP_W-1:0]  hp_q;
  logic signed [PV_W-1:0]  p_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag_q;
  logic [IDX_W-1:0]        idx_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [15:0]             a_q, b_q, y_q;
  logic signed [P_W-1:0]   prod_q;
  logic [X_W-1:0]          out_q;
  logic                    out_valid_q;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_d;
  logic                    mul_en;
  logic signed [P_W-1:0]   prod_rnd;
  logic signed [HP_W-1:0]  hp_sat;
  logic signed [D_W-1:0]   d_in;
  logic [MAG_W-1:0]        thresh_ext;
  logic [MAG_W-1:0]        excess;
  logic                    tbl_sat;
  logic [ADDR_W-1:0]       rom_addr;
  logic [15:0]             rom_data;
  logic [15:0]             diff;
  logic [15:0]             res_clip;
  logic signed [X_W-1:0]   res_out;

  assign thresh_ext = MAG_W'(cfg_i.thresh);
  assign excess     = mag_q - thresh_ext;
  assign tbl_sat    = |idx_q[IDX_W-1:TANH_LOG2];
  assign diff       = (!tbl_sat && (b_q >= a_q)) ? (b_q - a_q) : 16'd0;

  // difference term of the high-pass taken at load
  assign d_in = D_W'(last_hp_q[ch_i]) + D_W'($signed(x_i)) - D_W'(last_in_q[ch_i]);

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      OP_MUL_HP: begin
        mul_a = MA_W'(d_q);
        mul_b = MB_W'($signed({1'b0, cfg_i.hp_coef}));
      end
      OP_MUL_PRES: begin
        mul_a = MA_W'(hp_q);
        mul_b = MB_W'($signed({1'b0, cfg_i.presence}));
      end
      OP_MUL_SLOPE: begin
        mul_a = MA_W'($signed({1'b0, excess}));
        mul_b = MB_W'($signed({1'b0, cfg_i.slope}));
      end
      OP_MUL_DRIVE: begin
        mul_a = MA_W'($signed({1'b0, mag_q}));
        mul_b = MB_W'($signed({1'b0, cfg_i.drive}));
      end
      OP_MUL_FRAC: begin
        mul_a = MA_W'($signed({1'b0, diff}));
        mul_b = MB_W'($signed({1'b0, frac_q}));
      end
      OP_MUL_OUT: begin
        mul_a = MA_W'($signed({1'b0, y_q}));
        mul_b = MB_W'($signed({1'b0, cfg_i.out_gain}));
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // round half up of the previous product, then 24-bit saturation
  assign prod_rnd = (prod_q + RND_HALF) >>> Q_SHIFT;

  always_comb begin
    if (prod_rnd > HP_MAX_P) hp_sat = HP_W'(HP_MAX_P);
    else if (prod_rnd < HP_MIN_P) hp_sat = HP_W'(HP_MIN_P);
    else hp_sat = HP_W'(prod_rnd);
  end

  // table port
  always_comb begin
    if (cmd_i.op == OP_LUT_A) begin
      rom_addr = tbl_sat ? ADDR_W'(TANH_ENTRIES) : {1'b0, idx_q[TANH_LOG2-1:0]};
    end else begin
      rom_addr = {1'b0, idx_q[TANH_LOG2-1:0]} + ADDR_W'(1);
    end
  end
  assign rom_data = TANH_ROM[rom_addr];

  // output gain result clamped to the ceiling, then signed
  assign res_clip = (prod_rnd > P_W'(cfg_i.ceiling)) ? 16'(cfg_i.ceiling) : prod_rnd[15:0];
  assign res_out  = neg_q ? -$signed(res_clip) : $signed(res_clip);

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= $signed(x_i);
      ch_q <= ch_i;
      d_q  <= d_in;
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    unique case (cmd_i.op)
      OP_HP:    hp_q <= hp_sat;
      OP_MIX:   p_q  <= PV_W'(x_q) + PV_W'(prod_rnd);
      OP_KNEE: begin
        neg_q <= p_q[PV_W-1];
        mag_q <= p_q[PV_W-1] ? MAG_W'(-p_q) : MAG_W'(p_q);
      end
      OP_COMP: begin
        if (mag_q > thresh_ext) begin
          mag_q <= thresh_ext + MAG_W'(prod_rnd);
        end
      end
      OP_INDEX: begin
        idx_q  <= prod_q[DRV_PROD_W-1:FRAC_W];
        frac_q <= prod_q[FRAC_W-1:0];
      end
      OP_LUT_A:  a_q <= rom_data;
      OP_LUT_B:  b_q <= rom_data;
      OP_INTERP: y_q <= a_q + prod_q[FRAC_W+15:FRAC_W];
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q <= (cmd_i.op == OP_BYPASS) ? x_q : res_out;
    end
  end

  // history update and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_in_q[0] <= '0;
      last_in_q[1] <= '0;
      last_hp_q[0] <= '0;
      last_hp_q[1] <= '0;
    end else if (hist_clr_i) begin
      last_in_q[0] <= '0;
      last_in_q[1] <= '0;
      last_hp_q[0] <= '0;
      last_hp_q[1] <= '0;
    end else if (cmd_i.op == OP_HP) begin
      last_in_q[ch_q] <= x_q;
      last_hp_q[ch_q] <= hp_sat;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // processed results never exceed the ceiling
  a_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.op == OP_FINAL) |=>
      ($signed({out_q[X_W-1], out_q}) <= $signed({2'b00, cfg_i.ceiling}) &&
       $signed({out_q[X_W-1], out_q}) >= -$signed({2'b00, cfg_i.ceiling})))
    else $error("result outside limiter ceiling");

  // history clear leaves both slots at zero
  a_hist_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_clr_i |=> (last_in_q[0] == '0 && last_in_q[1] == '0 &&
                    last_hp_q[0] == '0 && last_hp_q[1] == '0))
    else $error("history not cleared");

endmodule

// ----- hw/rtl/voice_presence_compress_saturate_core.sv -----
// enabled samples step through the sequencer from the high-pass multiply to the output
//   gain multiply, then a final step loads the output register once it is free; disabled
//   samples go straight to that final step (pass-through). A new sample is taken only when
//   the sequencer is idle again; every multiply step of the chain uses the single shared multiplier
// reset: registers return to their defaults, effect off, both history slots zero,
//   output register empty
module voice_presence_compress_saturate_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [15:0] sample_in
  input  logic [0:0]                        s_axis_tuser,  // [0] channel_sel
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [15:0] sample_out
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vpcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vpcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import vpcs_pkg::*;

  cfg_t    cfg;
  logic    hist_clr;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file
  vpcs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .hist_clr_o  (hist_clr)
  );

  // step sequencer
  vpcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .enable_i  (cfg.enable),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // arithmetic, history and output register
  vpcs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .hist_clr_i  (hist_clr),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .x_i         (s_axis_tdata),
    .ch_i        (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
